>>> src/assert_macros.svh
// Assertion helper macros shared by the RTL.
// Assumes the including module has clk_i and active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is held.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> src/wsdps_pkg.sv
// Package for the delay-line pitch shifter: item codes and fixed constants.
// No dependencies.
`default_nettype none

package wsdps_pkg;

  // Sample and coefficient width
  localparam int unsigned SAMPLE_W = 16;

  // Longest ring the sample counter ever uses
  localparam int unsigned RING_LEN_CAP = 64000;

  // Q28 fixed point used to build the window table
  localparam longint Q28_ONE   = 64'sd268435456;
  localparam longint PI_Q28    = 64'sd843314857;
  localparam int     TAYLOR_N  = 12;
  localparam longint WIN_DIV   = 100 * Q28_ONE;
  localparam longint WIN_HALF  = 50 * Q28_ONE;

  // Divisors of successive cosine Taylor terms: (2i+1)(2i+2)
  localparam longint TAYLOR_DIV [TAYLOR_N] = '{
    64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132,
    64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552
  };

  // Input item kinds
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

endpackage

`default_nettype wire

>>> src/wsdps_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone, no package dependency.
`default_nettype none

module wsdps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> src/windowed_sweeping_delay_pitch_shift.sv
// Delay-line pitch shifter, two sweeping taps cross-faded by a Hamming window.
// Input beats carry req_type_i / sample_in_i / effect_on_i on in_valid_i / in_ready_o.
// A sample beat writes the ring and yields one output beat (dac_value_o,
// effect_led_o) on out_valid_o / out_ready_i; a tick beat advances both sweep
// delays and yields no output beat.
// Throughput: one input beat per cycle while out_ready_i keeps the pipe moving.
// The ring is one memory with a write port and two read ports, so both taps and
// the write of a sample happen in the cycle of its acceptance.
// An accepted sample beat passes the ring read, the window multiply, and the sum
// and saturate into the output register before its output beat is valid.
// When the receiver stalls, the whole pipe holds and in_ready_o drops for as
// long as a finished beat waits and out_ready_i is low.
// Reset (rst_ni low, asynchronous) clears the write index to zero, delay A to
// zero and delay B to the tap spacing, and empties the pipe. The ring is not
// cleared: a tap may read an unwritten entry, which matters only with the effect on.
// Uses wsdps_pkg, wsdps_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module windowed_sweeping_delay_pitch_shift #(
  parameter int unsigned RING_DEPTH       = 65536,
  parameter int unsigned SWEEP_MAX        = 1024,
  parameter int unsigned TAP_SPACING      = 512,
  parameter int unsigned WINDOW_FRAC_BITS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] sample_in_i,
  input  wire logic        effect_on_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] dac_value_o,
  output logic             effect_led_o
);

  localparam int unsigned SW       = wsdps_pkg::SAMPLE_W;
  localparam int unsigned AddrW    = $clog2(RING_DEPTH);
  localparam int unsigned DlyW     = $clog2(SWEEP_MAX + 1);
  localparam int unsigned RING_LEN = (RING_DEPTH < wsdps_pkg::RING_LEN_CAP) ?
                                     RING_DEPTH : wsdps_pkg::RING_LEN_CAP;
  localparam logic [AddrW:0]  RING_LEN_W  = (AddrW + 1)'(RING_LEN);
  localparam int unsigned     DLY_B_INIT  = TAP_SPACING % (SWEEP_MAX + 1);
  localparam logic [DlyW-1:0] DLY_MAX     = DlyW'(SWEEP_MAX);
  localparam logic [DlyW:0]   DLY_PERIOD  = (DlyW + 1)'(SWEEP_MAX + 1);

  typedef logic [SW-1:0] win_rom_t [SWEEP_MAX + 1];

  // Hamming coefficient n, from a Q28 Taylor cosine on the angle folded to [0, pi]
  function automatic logic [SW-1:0] win_coef(input int unsigned n);
    logic [63:0] k;
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic [63:0] w;
    longint      acc;
    longint      num;
    k = 64'(n % SWEEP_MAX);
    if (2 * k > 64'(SWEEP_MAX)) begin
      k = 64'(SWEEP_MAX) - k;
    end
    theta  = (64'(wsdps_pkg::PI_Q28) * 64'd2 * k) / 64'(SWEEP_MAX);
    theta2 = (theta * theta) >> 28;
    term   = 64'(wsdps_pkg::Q28_ONE);
    acc    = wsdps_pkg::Q28_ONE;
    for (int i = 0; i < wsdps_pkg::TAYLOR_N; i++) begin
      term = (term * theta2) >> 28;
      term = term / 64'(wsdps_pkg::TAYLOR_DIV[i]);
      if (i[0]) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
    end
    num = 54 * wsdps_pkg::Q28_ONE - 46 * acc;
    if (num < 0) begin
      num = 0;
    end
    w = ((64'(num) << WINDOW_FRAC_BITS) + 64'(wsdps_pkg::WIN_HALF))
        / 64'(wsdps_pkg::WIN_DIV);
    if (w > 64'hFFFF) begin
      w = 64'hFFFF;
    end
    return w[SW-1:0];
  endfunction

  function automatic win_rom_t build_win_rom();
    win_rom_t rom;
    for (int unsigned n = 0; n <= SWEEP_MAX; n++) begin
      rom[n] = win_coef(n);
    end
    return rom;
  endfunction

  localparam win_rom_t WIN_ROM = build_win_rom();

  // Handshake and pipe advance
  logic adv;
  logic in_acc;
  logic smp_acc;
  logic tick_acc;

  // Sweep state
  logic [AddrW-1:0] wr_idx_q, wr_idx_d;
  logic [AddrW:0]   wr_idx_inc;
  logic [DlyW-1:0]  delay_a_q, delay_a_d;
  logic [DlyW-1:0]  delay_b_q, delay_b_d;
  logic [SW-1:0]    win_a_q, win_b_q;
  logic [DlyW:0]    exp_dly_b_sum;
  logic [DlyW-1:0]  exp_dly_b;

  // Tap addressing
  logic [AddrW-1:0] dly_a_ext, dly_b_ext;
  logic [AddrW-1:0] off_a, off_b;

  // Ring read data
  logic [SW-1:0] rd_a, rd_b;

  // Stage 1: ring data arrives
  logic          valid1_q;
  logic          fx1_q;
  logic          fwd_a1_q, fwd_b1_q;
  logic [SW-1:0] smp1_q, wa1_q, wb1_q;
  logic [SW-1:0] tap_a, tap_b;

  // Stage 2: window products
  logic            valid2_q;
  logic            fx2_q;
  logic [SW-1:0]   smp2_q;
  logic [2*SW-1:0] pa2_q, pb2_q;
  logic [2*SW:0]   acc2;
  logic [2*SW:0]   acc2_shr;
  logic [SW-1:0]   sat2;

  // Output register
  logic          out_valid_q;
  logic [SW-1:0] dac_q;
  logic          led_q;

  assign adv      = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && adv;
  assign smp_acc  = in_acc && (wsdps_pkg::req_e'(req_type_i) == wsdps_pkg::REQ_SAMPLE);
  assign tick_acc = in_acc && (wsdps_pkg::req_e'(req_type_i) == wsdps_pkg::REQ_TICK);

  // Write index wraps at the ring length
  assign wr_idx_inc = {1'b0, wr_idx_q} + (AddrW + 1)'(1);
  always_comb begin
    wr_idx_d = wr_idx_q;
    if (smp_acc) begin
      wr_idx_d = (wr_idx_inc >= RING_LEN_W) ? '0 : wr_idx_inc[AddrW-1:0];
    end
  end

  // Sweep delays run 0..SWEEP_MAX and wrap
  always_comb begin
    delay_a_d = delay_a_q;
    delay_b_d = delay_b_q;
    if (tick_acc) begin
      delay_a_d = (delay_a_q >= DLY_MAX) ? '0 : delay_a_q + DlyW'(1);
      delay_b_d = (delay_b_q >= DLY_MAX) ? '0 : delay_b_q + DlyW'(1);
    end
  end

  // Window coefficients follow the delays, read from the next-state delay
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      delay_a_q <= '0;
      delay_b_q <= DlyW'(DLY_B_INIT);
      win_a_q   <= WIN_ROM[DlyW'(0)];
      win_b_q   <= WIN_ROM[DlyW'(DLY_B_INIT)];
    end else begin
      wr_idx_q  <= wr_idx_d;
      delay_a_q <= delay_a_d;
      delay_b_q <= delay_b_d;
      win_a_q   <= WIN_ROM[delay_a_d];
      win_b_q   <= WIN_ROM[delay_b_d];
    end
  end

  // Tap offsets: write index minus delay, wrapped into the ring
  assign dly_a_ext = AddrW'(delay_a_q);
  assign dly_b_ext = AddrW'(delay_b_q);
  always_comb begin
    if (wr_idx_q < dly_a_ext) begin
      off_a = AddrW'(RING_LEN_W - {1'b0, dly_a_ext - wr_idx_q});
    end else begin
      off_a = wr_idx_q - dly_a_ext;
    end
    if (wr_idx_q < dly_b_ext) begin
      off_b = AddrW'(RING_LEN_W - {1'b0, dly_b_ext - wr_idx_q});
    end else begin
      off_b = wr_idx_q - dly_b_ext;
    end
  end

  // Sample ring
  wsdps_ram #(
    .Width (SW),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (smp_acc),
    .waddr_i   (wr_idx_q),
    .wdata_i   (sample_in_i),
    .re_i      (smp_acc),
    .raddr_a_i (off_a),
    .raddr_b_i (off_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Pipe valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid1_q    <= smp_acc;
      valid2_q    <= valid1_q;
      out_valid_q <= valid2_q;
    end
  end

  // Stage 1 payload; a zero delay reads the sample being written
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q    <= effect_on_i;
      smp1_q   <= sample_in_i;
      fwd_a1_q <= (delay_a_q == '0);
      fwd_b1_q <= (delay_b_q == '0);
      wa1_q    <= win_a_q;
      wb1_q    <= win_b_q;
    end
  end

  assign tap_a = fwd_a1_q ? smp1_q : rd_a;
  assign tap_b = fwd_b1_q ? smp1_q : rd_b;

  // Stage 2: one multiply per tap
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx2_q  <= fx1_q;
      smp2_q <= smp1_q;
      pa2_q  <= wa1_q * tap_a;
      pb2_q  <= wb1_q * tap_b;
    end
  end

  // Sum, drop the window fraction, saturate
  assign acc2     = {1'b0, pa2_q} + {1'b0, pb2_q};
  assign acc2_shr = acc2 >> WINDOW_FRAC_BITS;
  assign sat2     = (acc2_shr > (2 * SW + 1)'({SW{1'b1}})) ? {SW{1'b1}} : acc2_shr[SW-1:0];

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dac_q <= fx2_q ? sat2 : smp2_q;
      led_q <= fx2_q;
    end
  end

  assign in_ready_o   = adv;
  assign out_valid_o  = out_valid_q;
  assign dac_value_o  = dac_q;
  assign effect_led_o = led_q;

  // Expected delay B from delay A and the fixed spacing
  assign exp_dly_b_sum = {1'b0, delay_a_q} + (DlyW + 1)'(DLY_B_INIT);
  assign exp_dly_b     = (exp_dly_b_sum >= DLY_PERIOD) ?
                         DlyW'(exp_dly_b_sum - DLY_PERIOD) : exp_dly_b_sum[DlyW-1:0];

  `ASSERT_RST(a_dly_range, (delay_a_q <= DLY_MAX) && (delay_b_q <= DLY_MAX), "sweep delay out of range")
  `ASSERT_RST(a_tap_spacing, delay_b_q == exp_dly_b, "tap spacing drifted")
  `ASSERT_RST(a_tick_keeps_idx, tick_acc |=> $stable(wr_idx_q), "tick moved the write index")
  `ASSERT_RST(a_idx_range, {1'b0, wr_idx_q} < RING_LEN_W, "write index past ring length")

endmodule

`default_nettype wire

>>> sim/windowed_sweeping_delay_pitch_shift_tb.sv
// Self-checking testbench for the two-tap sweeping delay pitch shifter.
// Drives sample and tick beats, predicts every output beat in-line and compares.
// Depends on wsdps_pkg and the windowed_sweeping_delay_pitch_shift top level.
`timescale 1ns / 1ps

module windowed_sweeping_delay_pitch_shift_tb;

  localparam int unsigned RING_DEPTH   = 65536;
  localparam int unsigned SWEEP_MAX    = 1024;
  localparam int unsigned TAP_SPACING  = 512;
  localparam int unsigned WIN_FRAC     = 15;
  localparam int unsigned RING_LEN     = (RING_DEPTH < wsdps_pkg::RING_LEN_CAP) ?
                                         RING_DEPTH : wsdps_pkg::RING_LEN_CAP;
  localparam int unsigned RING_AW      = $clog2(RING_LEN);
  localparam int unsigned WIN_AW       = $clog2(SWEEP_MAX + 1);
  localparam int unsigned RANDOM_BEATS = 420;
  localparam int unsigned QUIET_FIRST  = 150;
  localparam int unsigned QUIET_LAST   = 300;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_PRINTS   = 100;

  typedef longint unsigned u64_t;

  // Q28 constants for the window table
  localparam u64_t FIX_ONE = 64'd1 << 28;
  localparam u64_t FIX_PI  = 64'd843314857;

  typedef struct packed {
    logic [15:0] dac;
    logic        led;
  } dac_beat_t;

  // DUT ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        req_type_i  = wsdps_pkg::REQ_SAMPLE;
  logic [15:0] sample_in_i = 16'h0000;
  logic        effect_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] dac_value_o;
  logic        effect_led_o;

  // Predicted shifter state
  logic [15:0] win_coef [SWEEP_MAX + 1];
  logic [15:0] ring_mem [RING_LEN];
  bit          ring_written [RING_LEN];
  int unsigned wr_ptr;
  int unsigned sweep_a;
  int unsigned sweep_b;
  dac_beat_t   dac_expect_q [$];

  // Bookkeeping
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  bit          tx_quiet  = 1'b0;
  bit          rx_quiet  = 1'b0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned hold_left    = 0;
  dac_beat_t   got_exp;

  windowed_sweeping_delay_pitch_shift #(
    .RING_DEPTH      (RING_DEPTH),
    .SWEEP_MAX       (SWEEP_MAX),
    .TAP_SPACING     (TAP_SPACING),
    .WINDOW_FRAC_BITS(WIN_FRAC)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .sample_in_i (sample_in_i),
    .effect_on_i (effect_on_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dac_value_o (dac_value_o),
    .effect_led_o(effect_led_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hamming coefficient: cosine by truncated Taylor series on a folded angle
  function automatic logic [15:0] hamming_coef(int unsigned n);
    u64_t   k;
    u64_t   theta;
    u64_t   theta2;
    u64_t   term;
    u64_t   w;
    longint cos_fix;
    longint num;
    k = u64_t'(n % SWEEP_MAX);
    if (2 * k > u64_t'(SWEEP_MAX)) k = u64_t'(SWEEP_MAX) - k;
    theta   = (FIX_PI * 2 * k) / u64_t'(SWEEP_MAX);
    theta2  = (theta * theta) >> 28;
    term    = FIX_ONE;
    cos_fix = longint'(FIX_ONE);
    for (int i = 0; i < 12; i++) begin
      term = (term * theta2) >> 28;
      term = term / u64_t'((2 * i + 1) * (2 * i + 2));
      if (i % 2 == 1) cos_fix += longint'(term);
      else cos_fix -= longint'(term);
    end
    num = 54 * longint'(FIX_ONE) - 46 * cos_fix;
    if (num < 0) num = 0;
    // round half up to the window fraction
    w = (u64_t'(num) * (u64_t'(1) << WIN_FRAC) + 50 * FIX_ONE) / (100 * FIX_ONE);
    if (w > 64'hFFFF) w = 64'hFFFF;
    return w[15:0];
  endfunction

  function automatic logic [RING_AW-1:0] tap_index(int unsigned idx, int unsigned dly);
    if (idx < dly) return RING_AW'(RING_LEN - (dly - idx));
    return RING_AW'(idx - dly);
  endfunction

  // Both taps land on entries that hold data (a zero delay reads the beat itself)
  function automatic bit taps_written();
    return (sweep_a == 0 || ring_written[tap_index(wr_ptr, sweep_a)]) &&
           (sweep_b == 0 || ring_written[tap_index(wr_ptr, sweep_b)]);
  endfunction

  // Update the predicted state for one accepted beat; queue its output if any
  task automatic predict_shift(input wsdps_pkg::req_e kind, input logic [15:0] smp,
                               input logic fx);
    int unsigned da;
    int unsigned db;
    u64_t        acc;
    dac_beat_t   beat;
    if (kind == wsdps_pkg::REQ_TICK) begin
      sweep_a = (sweep_a >= SWEEP_MAX) ? 0 : sweep_a + 1;
      sweep_b = (sweep_b >= SWEEP_MAX) ? 0 : sweep_b + 1;
      return;
    end
    ring_mem[RING_AW'(wr_ptr)]     = smp;
    ring_written[RING_AW'(wr_ptr)] = 1'b1;
    if (fx) begin
      da  = (sweep_a > SWEEP_MAX) ? SWEEP_MAX : sweep_a;
      db  = (sweep_b > SWEEP_MAX) ? SWEEP_MAX : sweep_b;
      acc = u64_t'(win_coef[WIN_AW'(da)]) * u64_t'(ring_mem[tap_index(wr_ptr, da)]) +
            u64_t'(win_coef[WIN_AW'(db)]) * u64_t'(ring_mem[tap_index(wr_ptr, db)]);
      acc = acc >> WIN_FRAC;
      if (acc > 64'hFFFF) acc = 64'hFFFF;
      beat.dac = acc[15:0];
    end else begin
      beat.dac = smp;
    end
    beat.led = fx;
    dac_expect_q.push_back(beat);
    wr_ptr = (wr_ptr + 1 >= RING_LEN) ? 0 : wr_ptr + 1;
  endtask

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Send one input beat and wait for it to be taken
  task automatic send_beat(input wsdps_pkg::req_e kind, input logic [15:0] smp,
                           input logic fx);
    logic fx_ok;
    fx_ok = fx;
    // never point a tap at an entry that was not written
    if (kind == wsdps_pkg::REQ_SAMPLE && fx && !taps_written()) fx_ok = 1'b0;
    if (!tx_quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    sample_in_i <= smp;
    effect_on_i <= fx_ok;
    do @(posedge clk_i); while (!in_ready_o);
    predict_shift(kind, smp, fx_ok);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, quiet stretches, and a long hold on request
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 32);
    end
  end

  // Output beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dac_expect_q.size() == 0) begin
        report_mismatch($sformatf("output beat with none pending, dac=%h", dac_value_o));
      end else begin
        got_exp = dac_expect_q.pop_front();
        if (dac_value_o !== got_exp.dac)
          report_mismatch($sformatf("dac_value %h, predicted %h", dac_value_o, got_exp.dac));
        if (effect_led_o !== got_exp.led)
          report_mismatch($sformatf("effect_led %b, predicted %b", effect_led_o, got_exp.led));
      end
    end
  end

  // Bypass extremes and ignored fields of a tick
  task automatic test_bypass_extremes();
    tx_quiet = 1'b0;
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h0000, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'hFFFF, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h8000, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h7FFF, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h5555, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'hAAAA, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h0001, 1'b0);
    send_beat(wsdps_pkg::REQ_TICK,   16'hFFFF, 1'b1);
    send_beat(wsdps_pkg::REQ_TICK,   16'h0000, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h1234, 1'b0);
  endtask

  // Fill back to tap B with full scale so both taps read it: the sum saturates.
  // Delay A is still zero, so tap A reads the beat itself.
  task automatic test_constant_fill();
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    repeat (sweep_b + 1) send_beat(wsdps_pkg::REQ_SAMPLE, 16'hFFFF, 1'b0);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'hFFFF, 1'b1);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h0000, 1'b1);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h8000, 1'b1);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'hFFFF, 1'b1);
    rx_quiet <= 1'b0;
  endtask

  // Step delay B through its end point and the wrap to zero
  task automatic test_sweep_wrap();
    tx_quiet = 1'b0;
    while (sweep_b != SWEEP_MAX) begin
      if ($urandom_range(99) < 5) send_beat(wsdps_pkg::REQ_SAMPLE, pick_sample(), 1'b1);
      send_beat(wsdps_pkg::REQ_TICK, 16'($urandom), 1'($urandom_range(1)));
    end
    send_beat(wsdps_pkg::REQ_SAMPLE, pick_sample(), 1'b1);
    send_beat(wsdps_pkg::REQ_TICK, 16'h0000, 1'b1);
    // delay B now zero: tap reads the beat just written
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'hFFFF, 1'b1);
    send_beat(wsdps_pkg::REQ_SAMPLE, 16'h4321, 1'b1);
  endtask

  // Long receiver hold while beats keep coming, so the input side stalls
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (40) send_beat(wsdps_pkg::REQ_SAMPLE, pick_sample(), 1'b1);
    tx_quiet = 1'b0;
  endtask

  // Random mix of ticks, effect beats and bypass beats
  task automatic test_random_mix();
    int unsigned pick;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == QUIET_FIRST) begin
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
      end else if (n == QUIET_LAST) begin
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
      end
      pick = $urandom_range(99);
      if (pick < 25) send_beat(wsdps_pkg::REQ_TICK, 16'($urandom), 1'($urandom_range(1)));
      else send_beat(wsdps_pkg::REQ_SAMPLE, pick_sample(), pick < 80);
    end
  endtask

  initial begin
    for (int n = 0; n <= SWEEP_MAX; n++) win_coef[WIN_AW'(n)] = hamming_coef(n);
    wr_ptr  = 0;
    sweep_a = 0;
    sweep_b = TAP_SPACING % (SWEEP_MAX + 1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_constant_fill();
    test_bypass_extremes();
    test_random_mix();
    test_backpressure();
    test_sweep_wrap();

    in_valid_i <= 1'b0;
    rx_quiet   <= 1'b1;
    while (dac_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
